### rtl/lru_object_cache_directory_assert.svh
// Assertion macros shared by the object cache directory RTL.
// Needs nothing else; included by the files that check their own logic.
`ifndef LRU_OBJECT_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_OBJECT_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LRUOCD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRUOCD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lruocd_pkg.sv
// Shared types and constants of the object cache directory.
// No dependencies; imported by lruocd_cell and lru_object_cache_directory.
`timescale 1ns / 1ps

package lruocd_pkg;

   localparam int NUM_LINES_DEF = 10;
   localparam int KEY_BITS_DEF  = 64;
   localparam int MAX_SIZE_DEF  = 102400;

   localparam int KEY_W  = 64;   // width of the key field on the port
   localparam int SIZE_W = 17;   // width of every size field

   typedef enum logic {
      ACT_LOOKUP = 1'b0,
      ACT_INSERT = 1'b1
   } action_type;

   // Search link passed from cell to cell, most recent first.
   typedef struct packed {
      logic seen;    // an earlier cell already stopped the search
      logic valid;   // valid mark of the cell that stopped it
   } link_type;

endpackage

### rtl/lruocd_cell.sv
// One recency position of the directory: entry storage, compare and shift.
// Depends on lruocd_pkg.
`timescale 1ns / 1ps

module lruocd_cell import lruocd_pkg::*; #(
   parameter int INDEX    = 0,
   parameter bit IS_LAST  = 1'b0,
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int SLOT_W   = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_insert,
   input  logic                move,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic [KEY_BITS-1:0] prev_key,
   input  logic [SIZE_W-1:0]   prev_size,
   input  logic [SLOT_W-1:0]   prev_slot,
   input  logic                prev_valid,
   output logic [KEY_BITS-1:0] cur_key,
   output logic [SIZE_W-1:0]   cur_size,
   output logic [SLOT_W-1:0]   cur_slot,
   output logic                cur_valid,
   input  link_type            link_in,
   output link_type            link_out,
   input  logic [SLOT_W-1:0]   pick_slot_in,
   input  logic [SIZE_W-1:0]   pick_size_in,
   output logic [SLOT_W-1:0]   pick_slot_out,
   output logic [SIZE_W-1:0]   pick_size_out
);

   logic [KEY_BITS-1:0] key_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                valid_ff;
   logic                stop;
   logic                sel;
   logic                shift;

   // lookup stops at a hole or a key match; insert stops at a hole or the tail
   assign stop  = op_insert ? (!valid_ff || IS_LAST) : (!valid_ff || (key_ff == req_key));
   assign sel   = !link_in.seen && stop;
   // every position up to and including the chosen one takes its neighbor
   assign shift = move && !link_in.seen;

   always_comb begin
      link_out.seen  = link_in.seen || stop;
      link_out.valid = sel ? valid_ff : link_in.valid;
      pick_slot_out  = sel ? slot_ff  : pick_slot_in;
      pick_size_out  = sel ? size_ff  : pick_size_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= SLOT_W'(INDEX);
      end else if (shift) begin
         valid_ff <= prev_valid;
         slot_ff  <= prev_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         key_ff  <= prev_key;
         size_ff <= prev_size;
      end
   end

   assign cur_key   = key_ff;
   assign cur_size  = size_ff;
   assign cur_slot  = slot_ff;
   assign cur_valid = valid_ff;

endmodule

### rtl/lru_object_cache_directory.sv
// Top level of the fully associative LRU object cache directory.
// Depends on lruocd_pkg, lruocd_cell and lru_object_cache_directory_assert.svh.
`timescale 1ns / 1ps
//
// Usage
//   Request channel (req_*): one beat carries an action (lookup or insert),
//   a 64-bit key digest (low KEY_BITS used) and, for insert, an object size.
//   Response channel (rsp_*): exactly one beat per request, in order, with
//   hit, the physical slot of the object bytes and the stored size.
//   Lookup: first valid entry in recency order whose key matches; a nonzero
//   size is a hit and moves the entry to the front. Insert: fills the first
//   empty position, else evicts the least recent, and moves it to the front.
//   Order: a request sits in the request register until the chain runs
//   it into the output register; the recency chain does one compare pass
//   plus its move-to-front shift in the same cycle, and the request register
//   in front of it holds one request at a time, so the next one waits.
//   Reset: all entries invalid, recency order slot 0 .. NUM_LINES-1; no
//   clearing pass, the directory is usable right after reset.
//   Stall: a response waiting under rsp_stall sits in the output register;
//   one more request is still accepted and then waits in the request
//   register until the response slot frees up.
//
module lru_object_cache_directory import lruocd_pkg::*; #(
   parameter int NUM_LINES = NUM_LINES_DEF,
   parameter int KEY_BITS  = KEY_BITS_DEF,
   parameter int MAX_SIZE  = MAX_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic [KEY_W-1:0]             req_key,
   input  logic [SIZE_W-1:0]            req_object_size,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic [$clog2(NUM_LINES)-1:0] rsp_slot_index,
   output logic [SIZE_W-1:0]            rsp_found_size
);

`include "lru_object_cache_directory_assert.svh"

   localparam int SLOT_W = $clog2(NUM_LINES);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // request register
   action_type          action_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [SIZE_W-1:0]   size_ff, size_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [SIZE_W-1:0]   rsp_size_ff;

   // chain wiring: index 0 is the front feed, index i+1 is cell i
   logic [KEY_BITS-1:0] e_key   [NUM_LINES+1];
   logic [SIZE_W-1:0]   e_size  [NUM_LINES+1];
   logic [SLOT_W-1:0]   e_slot  [NUM_LINES+1];
   logic                e_valid [NUM_LINES+1];
   link_type            link    [NUM_LINES+1];
   logic [SLOT_W-1:0]   pick_slot [NUM_LINES+1];
   logic [SIZE_W-1:0]   pick_size [NUM_LINES+1];

   logic                is_insert;
   logic                go;
   logic                lookup_hit;
   logic                move;
   logic [NUM_LINES-1:0] valid_vec;

   assign is_insert = (action_ff == ACT_INSERT);

   // one request in flight; accept only when the request register is free
   assign req_stall = (state_ff != ST_IDLE);
   // execute once the response register is empty or being drained
   assign go = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // oversized inserts saturate at MAX_SIZE
   always_comb begin
      if (32'(req_object_size) > 32'(MAX_SIZE)) size_in = SIZE_W'(MAX_SIZE);
      else size_in = req_object_size;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         action_ff <= action_type'(req_action);
         key_ff    <= req_key[KEY_BITS-1:0];
         size_ff   <= size_in;
      end
   end

   // search results come off the tail of the chain
   assign lookup_hit = !is_insert && link[NUM_LINES].seen && link[NUM_LINES].valid &&
                       (pick_size[NUM_LINES] != '0);
   assign move = go && (is_insert || lookup_hit);

   // front feed: the chosen entry re-enters at position 0
   assign e_key[0]   = key_ff;
   assign e_size[0]  = is_insert ? size_ff : pick_size[NUM_LINES];
   assign e_slot[0]  = pick_slot[NUM_LINES];
   assign e_valid[0] = 1'b1;

   assign link[0]      = '0;
   assign pick_slot[0] = '0;
   assign pick_size[0] = '0;

   for (genvar i = 0; i < NUM_LINES; i++) begin : g_cell
      lruocd_cell #(
         .INDEX    (i),
         .IS_LAST  (i == NUM_LINES - 1),
         .KEY_BITS (KEY_BITS),
         .SLOT_W   (SLOT_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .op_insert     (is_insert),
         .move          (move),
         .req_key       (key_ff),
         .prev_key      (e_key[i]),
         .prev_size     (e_size[i]),
         .prev_slot     (e_slot[i]),
         .prev_valid    (e_valid[i]),
         .cur_key       (e_key[i+1]),
         .cur_size      (e_size[i+1]),
         .cur_slot      (e_slot[i+1]),
         .cur_valid     (e_valid[i+1]),
         .link_in       (link[i]),
         .link_out      (link[i+1]),
         .pick_slot_in  (pick_slot[i]),
         .pick_size_in  (pick_size[i]),
         .pick_slot_out (pick_slot[i+1]),
         .pick_size_out (pick_size[i+1])
      );
      assign valid_vec[i] = e_valid[i+1];
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_hit_ff  <= is_insert || lookup_hit;
         rsp_slot_ff <= (is_insert || lookup_hit) ? pick_slot[NUM_LINES] : '0;
         if (is_insert) rsp_size_ff <= size_ff;
         else if (lookup_hit) rsp_size_ff <= pick_size[NUM_LINES];
         else rsp_size_ff <= '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_found_size = rsp_size_ff;

   // every executed request leaves a response beat behind
   `LRUOCD_ASSERT_NEXT(a_go_gives_rsp, clock, reset, go, rsp_valid_ff, "execute lost response")
   // an insert always finds a victim position in the chain
   `LRUOCD_ASSERT_NOW(a_insert_picks, clock, reset, go && is_insert, link[NUM_LINES].seen,
      "insert found no position")
   // valid entries always form a prefix of the recency order
   `LRUOCD_ASSERT_NOW(a_valid_prefix, clock, reset, 1'b1,
      ((valid_vec + NUM_LINES'(1)) & valid_vec) == '0, "valid entries not a prefix")
   // a miss reports zero slot and zero size
   `LRUOCD_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff,
      rsp_slot_ff == '0 && rsp_size_ff == '0, "miss with nonzero payload")

endmodule
